FILE: design/cbm_pkg.sv
// Package for the circle/box collision manifold unit.
// Holds the queue word type, the back pipeline stage type and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

   localparam logic signed [15:0] NORM_POS  = 16'sh4000;
   localparam logic signed [15:0] NORM_NEG  = 16'shC000;
   localparam logic [14:0]        NORM_ONE  = 15'd16384;
   localparam logic [30:0]        DEPTH_MAX = 31'h7FFF_FFFF;
   localparam int NORM_SHIFT = 14;
   localparam int SQ_STEPS   = 31;
   localparam int DIV_STEPS  = 15;
   localparam int NUM_STAGES = SQ_STEPS + 1 + DIV_STEPS;

   typedef struct packed {
      logic               hit;
      logic               enclosed;
      logic               sx;
      logic               sy;
      logic [30:0]        ax;
      logic [30:0]        ay;
      logic [61:0]        d2;
      logic [30:0]        radius;
      logic [30:0]        in_depth;
      logic signed [15:0] in_nx;
      logic signed [15:0] in_ny;
   } q_entry_type;

   typedef struct packed {
      q_entry_type e;
      logic [61:0] rad;
      logic [62:0] root;
      logic [30:0] dlen;
      logic [46:0] remx;
      logic [46:0] remy;
      logic [14:0] qx;
      logic [14:0] qy;
   } bk_type;

endpackage
`default_nettype wire

FILE: design/circle_box_collision_manifold_unit.sv
// Top level of the circle/box collision manifold unit.
// Ties cbm_front, cbm_queue and cbm_back together; uses cbm_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | circle centre, radius, box corners
//   rsp     | out       | rsp_valid/rsp_stall  | hit, depth, normal_x, normal_y
//
// One pair per clock sustained while rsp is not stalled; the back end holds the
// 31-stage square root pipeline and the 15-stage normal divider.
// Reset is synchronous and clears only valid flags, queue pointers and the queue count.
// A stall on rsp freezes the back end; the queue absorbs the front end until it
// fills, then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module circle_box_collision_manifold_unit import cbm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_circle_x,
   input  logic signed [31:0] req_circle_y,
   input  logic [30:0]        req_radius,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [30:0]        rsp_depth,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y
);

   logic        push_valid, queue_full, pop, head_valid;
   q_entry_type push_data, head_data;

   cbm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_circle_x (req_circle_x),
      .req_circle_y (req_circle_y),
      .req_radius   (req_radius),
      .req_box_min_x(req_box_min_x),
      .req_box_min_y(req_box_min_y),
      .req_box_max_x(req_box_max_x),
      .req_box_max_y(req_box_max_y),
      .push_valid   (push_valid),
      .push_data    (push_data),
      .queue_full   (queue_full)
   );

   cbm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   cbm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_hit     (rsp_hit),
      .rsp_depth   (rsp_depth),
      .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y)
   );

endmodule
`default_nettype wire

FILE: design/cbm_front.sv
// Front end: clamps the centre, forms offsets, overlaps and squares, classifies
// each pair and pushes one word into the queue. Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbm_front import cbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_circle_x,
   input  logic signed [31:0] req_circle_y,
   input  logic [30:0]        req_radius,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   output logic               push_valid,
   output q_entry_type        push_data,
   input  logic               queue_full
);

   logic adv;

   // stage A
   logic               a_valid_ff;
   logic signed [31:0] xc, yc;
   logic [32:0] a_ox_in, a_oy_in, a_ox_ff, a_oy_ff;
   logic [33:0] a_dx_in, a_dy_in, a_dx_ff, a_dy_ff;
   logic [32:0] a_wx_in, a_wy_in, a_wx_ff, a_wy_ff;
   logic [30:0] a_r_ff;

   // stage B
   logic        b_valid_ff;
   logic [32:0] axf, ayf;
   logic [33:0] adx, ady;
   logic [34:0] ovx, ovy;
   logic        pick_x;
   logic [30:0] b_ax_ff, b_ay_ff, b_r_ff;
   logic        b_far_in, b_far_ff, b_zero_in, b_zero_ff, b_sx_ff, b_sy_ff;
   logic [34:0] b_ov_in, b_ov_ff;
   logic signed [15:0] b_nx_in, b_ny_in, b_nx_ff, b_ny_ff;

   // stage C
   logic        c_valid_ff;
   logic [61:0] c_ax2_in, c_ay2_in, c_r2_in, c_ax2_ff, c_ay2_ff, c_r2_ff;
   logic [34:0] half, dsum;
   logic [30:0] c_depth_in, c_depth_ff, c_ax_ff, c_ay_ff, c_r_ff;
   logic        c_far_ff, c_zero_ff, c_sx_ff, c_sy_ff;
   logic signed [15:0] c_nx_ff, c_ny_ff;
   logic [62:0] d2;

   assign adv        = !(c_valid_ff && queue_full);
   assign req_stall  = !adv;
   assign push_valid = c_valid_ff && !queue_full;

   // clamp onto the box, lower corner first
   always_comb begin
      xc = (req_circle_x < req_box_min_x) ? req_box_min_x :
           ((req_circle_x > req_box_max_x) ? req_box_max_x : req_circle_x);
      yc = (req_circle_y < req_box_min_y) ? req_box_min_y :
           ((req_circle_y > req_box_max_y) ? req_box_max_y : req_circle_y);
      a_ox_in = {xc[31], xc} - {req_circle_x[31], req_circle_x};
      a_oy_in = {yc[31], yc} - {req_circle_y[31], req_circle_y};
      a_dx_in = {req_circle_x[31], req_circle_x, 1'b0}
              - {{2{req_box_min_x[31]}}, req_box_min_x}
              - {{2{req_box_max_x[31]}}, req_box_max_x};
      a_dy_in = {req_circle_y[31], req_circle_y, 1'b0}
              - {{2{req_box_min_y[31]}}, req_box_min_y}
              - {{2{req_box_max_y[31]}}, req_box_max_y};
      a_wx_in = {req_box_max_x[31], req_box_max_x} - {req_box_min_x[31], req_box_min_x};
      a_wy_in = {req_box_max_y[31], req_box_max_y} - {req_box_min_y[31], req_box_min_y};
   end

   always_comb begin
      axf      = a_ox_ff[32] ? (33'd0 - a_ox_ff) : a_ox_ff;
      ayf      = a_oy_ff[32] ? (33'd0 - a_oy_ff) : a_oy_ff;
      b_far_in = axf[32] | axf[31] | ayf[32] | ayf[31];
      b_zero_in = (a_ox_ff == 33'd0) && (a_oy_ff == 33'd0);
      adx      = a_dx_ff[33] ? (34'd0 - a_dx_ff) : a_dx_ff;
      ady      = a_dy_ff[33] ? (34'd0 - a_dy_ff) : a_dy_ff;
      ovx      = {{2{a_wx_ff[32]}}, a_wx_ff} - {1'b0, adx};
      ovy      = {{2{a_wy_ff[32]}}, a_wy_ff} - {1'b0, ady};
      // tie goes to y
      pick_x   = $signed(ovx) < $signed(ovy);
      b_ov_in  = pick_x ? ovx : ovy;
      b_nx_in  = pick_x ? (a_dx_ff[33] ? NORM_POS : NORM_NEG) : 16'sd0;
      b_ny_in  = pick_x ? 16'sd0 : (a_dy_ff[33] ? NORM_POS : NORM_NEG);
   end

   always_comb begin
      c_ax2_in = 62'(b_ax_ff) * 62'(b_ax_ff);
      c_ay2_in = 62'(b_ay_ff) * 62'(b_ay_ff);
      c_r2_in  = 62'(b_r_ff) * 62'(b_r_ff);
      // round half up, then saturate
      half       = (35'(b_ov_ff[33:0]) + 35'd1) >> 1;
      dsum       = 35'(b_r_ff) + half;
      c_depth_in = (dsum > 35'(DEPTH_MAX)) ? DEPTH_MAX : dsum[30:0];
   end

   always_comb begin
      d2                 = {1'b0, c_ax2_ff} + {1'b0, c_ay2_ff};
      push_data.hit      = !c_far_ff && (d2 < {1'b0, c_r2_ff});
      push_data.enclosed = c_zero_ff;
      push_data.sx       = c_sx_ff;
      push_data.sy       = c_sy_ff;
      push_data.ax       = c_ax_ff;
      push_data.ay       = c_ay_ff;
      push_data.d2       = d2[61:0];
      push_data.radius   = c_r_ff;
      push_data.in_depth = c_depth_ff;
      push_data.in_nx    = c_nx_ff;
      push_data.in_ny    = c_ny_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ox_ff    <= a_ox_in;
         a_oy_ff    <= a_oy_in;
         a_dx_ff    <= a_dx_in;
         a_dy_ff    <= a_dy_in;
         a_wx_ff    <= a_wx_in;
         a_wy_ff    <= a_wy_in;
         a_r_ff     <= req_radius;
         b_ax_ff    <= axf[30:0];
         b_ay_ff    <= ayf[30:0];
         b_far_ff   <= b_far_in;
         b_zero_ff  <= b_zero_in;
         b_sx_ff    <= a_ox_ff[32];
         b_sy_ff    <= a_oy_ff[32];
         b_ov_ff    <= b_ov_in;
         b_nx_ff    <= b_nx_in;
         b_ny_ff    <= b_ny_in;
         b_r_ff     <= a_r_ff;
         c_ax2_ff   <= c_ax2_in;
         c_ay2_ff   <= c_ay2_in;
         c_r2_ff    <= c_r2_in;
         c_depth_ff <= c_depth_in;
         c_ax_ff    <= b_ax_ff;
         c_ay_ff    <= b_ay_ff;
         c_r_ff     <= b_r_ff;
         c_far_ff   <= b_far_ff;
         c_zero_ff  <= b_zero_ff;
         c_sx_ff    <= b_sx_ff;
         c_sy_ff    <= b_sy_ff;
         c_nx_ff    <= b_nx_ff;
         c_ny_ff    <= b_ny_ff;
      end
   end

endmodule
`default_nettype wire

FILE: design/cbm_queue.sv
// Small register queue between the front end and the back end.
// Depends on cbm_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none
module cbm_queue import cbm_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output q_entry_type head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   q_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: design/cbm_back.sv
// Back end: pipelined integer square root, pipelined normal divider and the
// result register. Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbm_back import cbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  q_entry_type        head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [30:0]        rsp_depth,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y
);

   function automatic bk_type sq_step(input bk_type s, input int k);
      bk_type      o;
      logic [62:0] bitv;
      logic [62:0] t;
      o    = s;
      bitv = 63'(1) << (2 * (SQ_STEPS - 1 - k));
      t    = s.root + bitv;
      if ({1'b0, s.rad} >= t) begin
         o.rad  = s.rad - t[61:0];
         o.root = (s.root >> 1) + bitv;
      end else begin
         o.root = s.root >> 1;
      end
      return o;
   endfunction

   function automatic bk_type prep_step(input bk_type s);
      bk_type o;
      o      = s;
      o.dlen = s.root[30:0];
      o.remx = {2'b00, s.e.ax, NORM_SHIFT'(0)} + 47'(s.root[30:1]);
      o.remy = {2'b00, s.e.ay, NORM_SHIFT'(0)} + 47'(s.root[30:1]);
      o.qx   = '0;
      o.qy   = '0;
      return o;
   endfunction

   function automatic bk_type div_step(input bk_type s, input int j);
      bk_type      o;
      logic [46:0] dv;
      o  = s;
      dv = 47'(s.dlen) << j;
      if (s.remx >= dv) begin
         o.remx = s.remx - dv;
         o.qx   = s.qx | (15'(1) << j);
      end
      if (s.remy >= dv) begin
         o.remy = s.remy - dv;
         o.qy   = s.qy | (15'(1) << j);
      end
      return o;
   endfunction

   logic adv;
   logic [NUM_STAGES-1:0] vld_ff;
   bk_type head_st;
   bk_type src   [NUM_STAGES];
   bk_type st_in [NUM_STAGES];
   bk_type st_ff [NUM_STAGES];
   bk_type last;
   logic [14:0] qcx, qcy;

   logic               rsp_valid_ff, hit_in, hit_ff;
   logic [30:0]        depth_in, depth_ff;
   logic signed [15:0] nx_in, ny_in, nx_ff, ny_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && head_valid;

   always_comb begin
      head_st     = '0;
      head_st.e   = head_data;
      head_st.rad = head_data.d2;
   end

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      if (k > 0) begin : g_link
         assign src[k] = st_ff[k-1];
      end else begin : g_head
         assign src[k] = head_st;
      end
      if (k < SQ_STEPS) begin : g_sq
         assign st_in[k] = sq_step(src[k], k);
      end else if (k == SQ_STEPS) begin : g_prep
         assign st_in[k] = prep_step(src[k]);
      end else begin : g_div
         assign st_in[k] = div_step(src[k], NUM_STAGES - 1 - k);
      end
   end

   always_comb begin
      last = st_ff[NUM_STAGES-1];
      qcx  = (last.qx > NORM_ONE) ? NORM_ONE : last.qx;
      qcy  = (last.qy > NORM_ONE) ? NORM_ONE : last.qy;
      hit_in   = last.e.hit;
      depth_in = '0;
      nx_in    = '0;
      ny_in    = '0;
      if (last.e.hit) begin
         if (last.e.enclosed) begin
            depth_in = last.e.in_depth;
            nx_in    = last.e.in_nx;
            ny_in    = last.e.in_ny;
         end else begin
            depth_in = last.e.radius - last.dlen;
            nx_in    = last.e.sx ? -$signed({1'b0, qcx}) : $signed({1'b0, qcx});
            ny_in    = last.e.sy ? -$signed({1'b0, qcy}) : $signed({1'b0, qcy});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NUM_STAGES-2:0], head_valid};
         rsp_valid_ff <= vld_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
         hit_ff   <= hit_in;
         depth_ff <= depth_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_depth    = depth_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;

endmodule
`default_nettype wire
